// ===== hw/rtl/plac_pkg.sv =====
// Shared constants and types for the packet length autocorrelation block.
`timescale 1ns / 1ps
`default_nettype none
package plac_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int LENGTH_BITS = 16;
  localparam int LAG_COUNT   = 5;
  localparam int LAG_W       = 3;
  localparam int IN_LEN_W    = 16;

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = LENGTH_BITS + ADDR_W;
  localparam int D_W    = LENGTH_BITS + ADDR_W + 1;   // n*x - S, signed
  localparam int P_W    = 2 * D_W;
  localparam int ACC_W  = P_W + ADDR_W;

  // Q4.16 result: 3 integer quotient bits plus 16 fraction bits, then sign.
  localparam int Q_FRAC  = 16;
  localparam int Q_INT   = 3;
  localparam int Q_STEPS = Q_FRAC + Q_INT;
  localparam int VAL_W   = Q_STEPS + 1;

  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic signed [ACC_W-1:0] num;
    logic signed [ACC_W-1:0] den;
  } acc_t;

endpackage
`default_nettype wire

// ===== hw/rtl/packet_length_autocorrelation.sv =====
// Top level: loads one flow of packet lengths, then gives autocorrelation for lags 1 to 5.
//
// Input stream: one packet length per beat in in_tdata; in_tlast marks the last packet of
// the flow. Lengths are written to a 256-entry sample store at one beat per cycle; beats
// beyond the store's capacity are dropped and flagged on the results.
// The beat with in_tlast closes the flow; in_tready then stays low until the fifth result
// has been loaded into the output register. For each lag the store is read through two
// ports, one sample pair per cycle (n - lag pairs), followed by pipeline drain and a
// restoring divide that ends early when the ratio saturates or the denominator is zero.
// Flows of 5 samples or fewer skip the read passes and give a zero value for every lag.
// Output stream: five beats, lag 1 to 5, each held in an output register; out_tlast is
// set on lag 5. When the receiver stalls, the sequencer waits before loading the next
// result, and the first beat of the next flow is taken while lag 5 is still waiting.
// Reset (rst_n low, synchronous) empties the flow state and the output register; the
// sample store keeps no reset and only entries written in the current flow are read.
`timescale 1ns / 1ps
`default_nettype none
module packet_length_autocorrelation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] packet_length
  input  wire logic        in_tlast,   // last_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [2:0] lag_index, [22:3] autocorr_value, [23] zero
  output logic             out_tuser,  // overflowed
  output logic             out_tlast   // last_result
);
  import plac_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [LAG_W-1:0] LAST_LAG = LAG_W'(LAG_COUNT);

  logic [2:0]        state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic              ovf_r;
  logic [LAG_W-1:0]  lag_r;
  logic [ADDR_W-1:0] i_r;
  logic              rd_pend_r;
  logic [VAL_W-1:0]  res_r;

  logic              out_tvalid_r;
  logic [LAG_W-1:0]  out_lag_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_ovf_r;
  logic              out_last_r;

  logic                   in_fire;
  logic [LENGTH_BITS-1:0] len;
  logic                   full;
  logic                   st_wr_en;
  logic                   rd_en;
  logic [CNT_W-1:0]       addr_b_wide;
  logic [LENGTH_BITS-1:0] rd_a, rd_b;
  logic                   last_pair;
  logic                   short_flow;
  logic                   out_free;
  logic                   out_load;
  logic                   mac_clr;
  logic                   mac_busy;
  acc_t                   acc;
  logic                   div_start;
  logic                   div_done;
  logic signed [VAL_W-1:0] div_val;

  assign in_tready   = (state_r == S_LOAD);
  assign in_fire     = in_tvalid & in_tready;
  assign len         = LENGTH_BITS'(in_tdata);
  assign full        = (cnt_r == CNT_W'(MAX_SAMPLES));
  assign st_wr_en    = in_fire & ~full;
  assign rd_en       = (state_r == S_ISSUE);
  assign addr_b_wide = CNT_W'(i_r) + CNT_W'(lag_r);
  assign last_pair   = (addr_b_wide + CNT_W'(1)) == cnt_r;
  assign short_flow  = cnt_r <= CNT_W'(LAG_COUNT);
  assign out_free    = ~out_tvalid_r | out_tready;
  assign out_load    = (state_r == S_OUT) & out_free;
  assign div_start   = (state_r == S_DRAIN) & ~rd_pend_r & ~mac_busy;
  assign mac_clr     = (state_r == S_START) | out_load;

  plac_store u_store (
    .clk       (clk),
    .wr_en     (st_wr_en),
    .wr_addr   (cnt_r[ADDR_W-1:0]),
    .wr_data   (len),
    .rd_en     (rd_en),
    .rd_addr_a (i_r),
    .rd_addr_b (addr_b_wide[ADDR_W-1:0]),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  plac_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (mac_clr),
    .in_valid (rd_pend_r),
    .smp_a    (rd_a),
    .smp_b    (rd_b),
    .n        (cnt_r),
    .s        (sum_r),
    .busy     (mac_busy),
    .acc      (acc)
  );

  plac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .acc   (acc),
    .done  (div_done),
    .value (div_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      sum_r     <= '0;
      ovf_r     <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_en;
      case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r + CNT_W'(1);
              sum_r <= sum_r + SUM_W'(len);
            end
            if (in_tlast) begin
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          lag_r <= LAG_W'(1);
          i_r   <= '0;
          res_r <= '0;
          state_r <= short_flow ? S_OUT : S_ISSUE;
        end
        S_ISSUE: begin
          i_r <= i_r + ADDR_W'(1);
          if (last_pair) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (div_start) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_r   <= div_val;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_lag_r    <= lag_r;
            out_val_r    <= res_r;
            out_ovf_r    <= ovf_r;
            out_last_r   <= (lag_r == LAST_LAG);
            if (lag_r == LAST_LAG) begin
              cnt_r   <= '0;
              sum_r   <= '0;
              ovf_r   <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              lag_r   <= lag_r + LAG_W'(1);
              i_r     <= '0;
              state_r <= short_flow ? S_OUT : S_ISSUE;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - VAL_W - LAG_W){1'b0}}, out_val_r, out_lag_r};
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // the store is only written while samples load, never during a read pass
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !st_wr_en)
    else $error("sample store written outside load phase");

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider result arrived unexpectedly");

  // the end-of-flow beat always carries the last lag
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[2:0] == LAST_LAG))
    else $error("tlast on a beat other than the last lag");

  // sample count never passes the store capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store capacity");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/plac_store.sv =====
// Sample store: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module plac_store (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [plac_pkg::ADDR_W-1:0]      wr_addr,
  input  wire logic [plac_pkg::LENGTH_BITS-1:0] wr_data,
  input  wire logic                             rd_en,
  input  wire logic [plac_pkg::ADDR_W-1:0]      rd_addr_a,
  input  wire logic [plac_pkg::ADDR_W-1:0]      rd_addr_b,
  output logic      [plac_pkg::LENGTH_BITS-1:0] rd_data_a,
  output logic      [plac_pkg::LENGTH_BITS-1:0] rd_data_b
);
  import plac_pkg::*;

  logic [LENGTH_BITS-1:0] mem [MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/plac_mac.sv =====
// Deviation, product and accumulate pipeline for one lag.
`timescale 1ns / 1ps
`default_nettype none
module plac_mac (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             clr,
  input  wire logic                             in_valid,
  input  wire logic [plac_pkg::LENGTH_BITS-1:0] smp_a,
  input  wire logic [plac_pkg::LENGTH_BITS-1:0] smp_b,
  input  wire logic [plac_pkg::CNT_W-1:0]       n,
  input  wire logic [plac_pkg::SUM_W-1:0]       s,
  output logic                                  busy,
  output plac_pkg::acc_t                        acc
);
  import plac_pkg::*;

  logic [CNT_W+LENGTH_BITS-1:0] nxa, nxb;
  logic signed [D_W-1:0] da_nxt, db_nxt;
  logic signed [D_W-1:0] da_r, db_r;
  logic signed [P_W-1:0] pa_r, pd_r;
  logic v1_r, v2_r;
  acc_t acc_r;

  // d = n*x - S; n*x < 2^(ADDR_W+LENGTH_BITS) so the top bit is always zero
  assign nxa    = n * smp_a;
  assign nxb    = n * smp_b;
  assign da_nxt = $signed(D_W'(nxa)) - $signed(D_W'(s));
  assign db_nxt = $signed(D_W'(nxb)) - $signed(D_W'(s));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    da_r <= da_nxt;
    db_r <= db_nxt;
    pa_r <= da_r * db_r;
    pd_r <= da_r * da_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r.num <= acc_r.num + ACC_W'(pa_r);
      acc_r.den <= acc_r.den + ACC_W'(pd_r);
    end
  end

  assign busy = in_valid | v1_r | v2_r;
  assign acc  = acc_r;

endmodule
`default_nettype wire

// ===== hw/rtl/plac_div.sv =====
// Restoring divider: num/den in signed Q4.16, truncated and saturated.
`timescale 1ns / 1ps
`default_nettype none
module plac_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire plac_pkg::acc_t              acc,
  output logic                             done,
  output logic signed [plac_pkg::VAL_W-1:0] value
);
  import plac_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_CHK  = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;

  localparam int STEP_W = $clog2(Q_STEPS);
  localparam int V_W    = ACC_W + Q_INT;
  localparam int R_W    = V_W + 1;
  localparam logic [VAL_W-1:0] MAG_SAT = VAL_W'(1) << Q_STEPS;
  localparam logic [VAL_W-1:0] POS_MAX = MAG_SAT - VAL_W'(1);

  logic [1:0]         state_r;
  logic [STEP_W-1:0]  step_r;
  logic [ACC_W-1:0]   mag_r;
  logic [V_W-1:0]     v_r;
  logic [R_W-1:0]     r_r;
  logic [Q_STEPS-1:0] q_r;
  logic               neg_r;
  logic               done_r;
  logic [VAL_W-1:0]   val_r;

  logic [R_W-1:0]     r_sh, r_nxt;
  logic               ge;
  logic [Q_STEPS-1:0] q_nxt;
  logic               done_nxt;

  function automatic logic [VAL_W-1:0] fmt(input logic neg, input logic [VAL_W-1:0] mag);
    if (neg) begin
      return VAL_W'(0) - mag;
    end
    return (mag > POS_MAX) ? POS_MAX : mag;
  endfunction

  // divisor scaled by 8 so the 19 quotient bits fall out of one shift loop
  assign r_sh  = r_r << 1;
  assign ge    = r_sh >= R_W'(v_r);
  assign r_nxt = ge ? (r_sh - R_W'(v_r)) : r_sh;
  assign q_nxt = {q_r[Q_STEPS-2:0], ge};

  assign done_nxt = ((state_r == D_IDLE) & start & (acc.den == '0)) |
                    ((state_r == D_CHK) & (V_W'(mag_r) >= v_r)) |
                    ((state_r == D_RUN) & (step_r == STEP_W'(Q_STEPS - 1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      case (state_r)
        D_IDLE: begin
          if (start) begin
            if (acc.den == '0) begin
              val_r <= '0;
            end else begin
              neg_r   <= acc.num[ACC_W-1];
              mag_r   <= acc.num[ACC_W-1] ? (ACC_W'(0) - acc.num) : acc.num;
              v_r     <= {acc.den, {Q_INT{1'b0}}};
              state_r <= D_CHK;
            end
          end
        end
        D_CHK: begin
          if (V_W'(mag_r) >= v_r) begin
            val_r   <= fmt(neg_r, MAG_SAT);
            state_r <= D_IDLE;
          end else begin
            r_r     <= R_W'(mag_r);
            q_r     <= '0;
            step_r  <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          r_r    <= r_nxt;
          q_r    <= q_nxt;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(Q_STEPS - 1)) begin
            val_r   <= fmt(neg_r, VAL_W'(q_nxt));
            state_r <= D_IDLE;
          end
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign done  = done_r;
  assign value = $signed(val_r);

endmodule
`default_nettype wire
